FILE: sv/isq_pkg.sv
// ----------------------------------------------------------------------------
// isq_pkg: shared definitions for the indexed sequence store
// Command and status codes, and the control and status groups that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package isq_pkg;

  localparam logic [3:0] CMD_PUSH_FRONT = 4'd0;
  localparam logic [3:0] CMD_PUSH_REAR  = 4'd1;
  localparam logic [3:0] CMD_INSERT     = 4'd2;
  localparam logic [3:0] CMD_POP_FRONT  = 4'd3;
  localparam logic [3:0] CMD_POP_REAR   = 4'd4;
  localparam logic [3:0] CMD_REMOVE     = 4'd5;
  localparam logic [3:0] CMD_FIND       = 4'd6;
  localparam logic [3:0] CMD_READ       = 4'd7;
  localparam logic [3:0] CMD_WRITE      = 4'd8;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  localparam logic [1:0] PTR_POS   = 2'd0;
  localparam logic [1:0] PTR_COUNT = 2'd1;
  localparam logic [1:0] PTR_ZERO  = 2'd2;

  typedef struct packed {
    logic       load;
    logic       ptr_load;
    logic [1:0] ptr_src;
    logic       shift_rd;
    logic       shift_up;
    logic       rd_ptr;
    logic       cap_value;
    logic       find_rd;
    logic       put;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       set_status;
    logic [1:0] status;
  } ctl_t;

  typedef struct packed {
    logic [3:0] cmd;
    logic       pos_gt_cnt;
    logic       pos_ge_cnt;
    logic       full;
    logic       empty;
    logic       ptr_eq_pos;
    logic       ptr_eq_last;
    logic       ptr_eq_cnt;
    logic       match;
    logic       fpend;
  } st_t;

endpackage

FILE: sv/isq_datapath.sv
// ----------------------------------------------------------------------------
// isq_datapath: entry memory, count, walk pointer and result registers
// Shifts move one entry per cycle through a registered read and a delayed
// write; searches compare one registered read per cycle.
// ----------------------------------------------------------------------------
module isq_datapath import isq_pkg::*; #(
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  ctl_t               ctl,
  output st_t                st,
  input  logic [3:0]         command,
  input  logic [CW-1:0]      position,
  input  logic signed [31:0] item_value,
  output logic [1:0]         status,
  output logic signed [31:0] result_value,
  output logic [AW-1:0]      result_index,
  output logic               found,
  output logic [CW-1:0]      count
);

  logic signed [31:0] mem [DEPTH];

  logic [3:0]         cmd_reg;
  logic [CW-1:0]      pos_reg;
  logic signed [31:0] val_reg;
  logic [CW-1:0]      cnt;
  logic [CW-1:0]      ptr;
  logic [CW-1:0]      ptr_dec;
  logic [CW-1:0]      ptr_inc;
  logic [CW-1:0]      eff_pos;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      wr_q;
  logic [AW-1:0]      fidx;
  logic [AW-1:0]      ridx;
  logic signed [31:0] rdata;
  logic signed [31:0] rval;
  logic               wr_pend;
  logic               fpend;
  logic               fnd;
  logic [1:0]         stat_reg;
  logic               match;

  assign ptr_dec = ptr - CW'(1);
  assign ptr_inc = ptr + CW'(1);
  assign match   = fpend && (rdata == val_reg);

  always_comb begin
    case (command)
      CMD_PUSH_FRONT, CMD_POP_FRONT: eff_pos = '0;
      CMD_PUSH_REAR:                 eff_pos = cnt;
      CMD_POP_REAR:                  eff_pos = cnt - CW'(1);
      default:                       eff_pos = position;
    endcase
  end

  always_comb begin
    if (ctl.shift_rd) begin
      rd_addr = ctl.shift_up ? ptr_dec[AW-1:0] : ptr_inc[AW-1:0];
    end else begin
      rd_addr = ptr[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift_rd || ctl.rd_ptr || ctl.find_rd) begin
      rdata <= mem[rd_addr];
    end
    if (wr_pend) begin
      mem[wr_q] <= rdata;
    end else if (ctl.put) begin
      mem[pos_reg[AW-1:0]] <= val_reg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      wr_pend <= 1'b0;
      fpend   <= 1'b0;
    end else begin
      wr_pend <= ctl.shift_rd;
      fpend   <= ctl.find_rd;
      if (ctl.cnt_inc) begin
        cnt <= cnt + CW'(1);
      end else if (ctl.cnt_dec) begin
        cnt <= cnt - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    wr_q <= ptr[AW-1:0];
    fidx <= ptr[AW-1:0];
    if (ctl.load) begin
      cmd_reg  <= command;
      pos_reg  <= eff_pos;
      val_reg  <= item_value;
      stat_reg <= ST_OK;
      rval     <= '0;
      ridx     <= '0;
      fnd      <= 1'b0;
    end else begin
      if (ctl.set_status) begin
        stat_reg <= ctl.status;
      end
      if (ctl.cap_value) begin
        rval <= rdata;
      end
      if (match && !fnd) begin
        fnd  <= 1'b1;
        ridx <= fidx;
      end
    end
    if (ctl.ptr_load) begin
      case (ctl.ptr_src)
        PTR_POS:   ptr <= pos_reg;
        PTR_COUNT: ptr <= cnt;
        default:   ptr <= '0;
      endcase
    end else if (ctl.shift_rd) begin
      ptr <= ctl.shift_up ? ptr_dec : ptr_inc;
    end else if (ctl.find_rd) begin
      ptr <= ptr_inc;
    end
  end

  always_comb begin
    st.cmd         = cmd_reg;
    st.pos_gt_cnt  = pos_reg > cnt;
    st.pos_ge_cnt  = pos_reg >= cnt;
    st.full        = cnt == CW'(DEPTH);
    st.empty       = cnt == '0;
    st.ptr_eq_pos  = ptr == pos_reg;
    st.ptr_eq_last = ptr_inc == cnt;
    st.ptr_eq_cnt  = ptr == cnt;
    st.match       = match;
    st.fpend       = fpend;
  end

  assign status       = stat_reg;
  assign result_value = rval;
  assign result_index = ridx;
  assign found        = fnd;
  assign count        = cnt;

endmodule

FILE: sv/isq_controller.sv
// ----------------------------------------------------------------------------
// isq_controller: command sequencer for the indexed sequence store
// Checks bounds, then steps the datapath through shifts, reads, searches
// and writes, and marks the result beat.
// ----------------------------------------------------------------------------
module isq_controller import isq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  output logic done,
  output ctl_t ctl,
  input  st_t  st
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECIDE = 4'd1;
  localparam logic [3:0] S_UP     = 4'd2;
  localparam logic [3:0] S_PUT    = 4'd3;
  localparam logic [3:0] S_RD     = 4'd4;
  localparam logic [3:0] S_CAP    = 4'd5;
  localparam logic [3:0] S_DOWN   = 4'd6;
  localparam logic [3:0] S_FIND   = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = state != S_IDLE;
  assign done = state == S_DONE;

  always_comb begin
    ctl        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          ctl.load   = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_next = S_DONE;
        if (st.cmd inside {CMD_PUSH_FRONT, CMD_PUSH_REAR, CMD_INSERT}) begin
          if (st.pos_gt_cnt) begin
            ctl.set_status = 1'b1;
            ctl.status     = ST_RANGE;
          end else if (st.full) begin
            ctl.set_status = 1'b1;
            ctl.status     = ST_FULL;
          end else begin
            ctl.ptr_load = 1'b1;
            ctl.ptr_src  = PTR_COUNT;
            state_next   = S_UP;
          end
        end else if (st.cmd inside {CMD_POP_FRONT, CMD_POP_REAR}) begin
          if (st.empty) begin
            ctl.set_status = 1'b1;
            ctl.status     = ST_EMPTY;
          end else begin
            ctl.ptr_load = 1'b1;
            ctl.ptr_src  = PTR_POS;
            state_next   = S_RD;
          end
        end else if (st.cmd inside {CMD_REMOVE, CMD_READ, CMD_WRITE}) begin
          if (st.pos_ge_cnt) begin
            ctl.set_status = 1'b1;
            ctl.status     = ST_RANGE;
          end else begin
            ctl.ptr_load = 1'b1;
            ctl.ptr_src  = PTR_POS;
            state_next   = (st.cmd == CMD_WRITE) ? S_PUT : S_RD;
          end
        end else if (st.cmd == CMD_FIND) begin
          ctl.ptr_load = 1'b1;
          ctl.ptr_src  = PTR_ZERO;
          state_next   = S_FIND;
        end
      end
      S_UP: begin
        if (st.ptr_eq_pos) begin
          state_next = S_PUT;
        end else begin
          ctl.shift_rd = 1'b1;
          ctl.shift_up = 1'b1;
        end
      end
      S_PUT: begin
        ctl.put     = 1'b1;
        ctl.cnt_inc = st.cmd != CMD_WRITE;
        state_next  = S_DONE;
      end
      S_RD: begin
        ctl.rd_ptr = 1'b1;
        state_next = S_CAP;
      end
      S_CAP: begin
        ctl.cap_value = 1'b1;
        state_next    = (st.cmd == CMD_READ) ? S_DONE : S_DOWN;
      end
      S_DOWN: begin
        if (st.ptr_eq_last) begin
          ctl.cnt_dec = 1'b1;
          state_next  = S_DONE;
        end else begin
          ctl.shift_rd = 1'b1;
        end
      end
      S_FIND: begin
        if (st.match) begin
          state_next = S_DONE;
        end else if (st.ptr_eq_cnt) begin
          if (!st.fpend) begin
            state_next = S_DONE;
          end
        end else begin
          ctl.find_rd = 1'b1;
        end
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/indexed_sequence_store.sv
// ----------------------------------------------------------------------------
// indexed_sequence_store: bounded ordered sequence of signed 32-bit values
// Push and pop at either end, insert and remove at a position, find, read
// and write, each command answering with one result beat.
//
//   Channel   Handshake        Beat
//   command   start / busy     command, position, item_value
//   result    done (strobe)    status, result_value, result_index, found, count
//
// A command is taken when start is high and busy is low. A rejected or
// unused command goes straight to its result beat; write first puts the
// entry, and read reads and captures it. Push, insert, pop and remove also
// shift every entry between position and the end, and find reads entries
// from 0 until a match or the count; shifts and searches move one entry
// per cycle through the single-read, single-write entry memory.
// Reset clears the count; entries need no clearing. The result beat cannot
// be held off, and the next command is taken the cycle after it.
// ----------------------------------------------------------------------------
module indexed_sequence_store import isq_pkg::*; #(
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         command,
  input  logic [CW-1:0]      position,
  input  logic signed [31:0] item_value,
  output logic               done,
  output logic [1:0]         status,
  output logic signed [31:0] result_value,
  output logic [AW-1:0]      result_index,
  output logic               found,
  output logic [CW-1:0]      count
);

  ctl_t ctl;
  st_t  st;

  isq_controller u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .ctl   (ctl),
    .st    (st)
  );

  isq_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .st           (st),
    .command      (command),
    .position     (position),
    .item_value   (item_value),
    .status       (status),
    .result_value (result_value),
    .result_index (result_index),
    .found        (found),
    .count        (count)
  );

endmodule
